// ===== hw/rtl/isub_pkg.sv =====
// ----------------------------------------------------------------------------
// isub_pkg: shared types and constants of the interval subscription matcher
// Field widths, default sizes, command codes and the controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package isub_pkg;

  localparam int SUB_ID_W  = 10;
  localparam int ATTR_W    = 5;
  localparam int VALUE_W   = 20;
  localparam int COUNT_W   = 11;
  localparam int NUM_ATTRS = 32;

  localparam int MAX_SUBS_DEF        = 1024;
  localparam int MAX_CONSTRAINTS_DEF = 4096;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_PUBLISH = 1'b1;

  typedef struct packed {
    logic [SUB_ID_W-1:0] sub_id;
    logic [ATTR_W-1:0]   attr;
    logic [VALUE_W-1:0]  low;
    logic [VALUE_W-1:0]  high;
  } entry_t;

  typedef struct packed {
    logic ins_en;
    logic pub_load;
    logic scan_step;
    logic sweep_step;
    logic clr_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic store_empty;
    logic scan_last;
    logic sweep_last;
    logic pub_last;
  } stat_t;

endpackage

// ===== hw/rtl/interval_subscription_matcher.sv =====
// ----------------------------------------------------------------------------
// interval_subscription_matcher: publish/subscribe interval matcher
// Stores interval constraints and counts the subscriptions an event meets.
// ----------------------------------------------------------------------------
// An insert word does not stall the input. A publish word scans the
// constraint store through its single read port, one entry a cycle. The
// last word of an event then sweeps the mark memory, one mark a cycle,
// counting and clearing, before the count enters the output register.
// After reset the mark memory is cleared, and no word is taken until
// that pass ends. A waiting result does not block inserts.
module interval_subscription_matcher #(
  parameter int MAX_SUBS        = isub_pkg::MAX_SUBS_DEF,
  parameter int MAX_CONSTRAINTS = isub_pkg::MAX_CONSTRAINTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [isub_pkg::SUB_ID_W-1:0] sub_id_i,
  input  logic [isub_pkg::ATTR_W-1:0]   attribute_i,
  input  logic [isub_pkg::VALUE_W-1:0]  low_bound_i,
  input  logic [isub_pkg::VALUE_W-1:0]  high_bound_i,
  input  logic [isub_pkg::VALUE_W-1:0]  event_value_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [isub_pkg::COUNT_W-1:0]  match_count_o
);

  isub_pkg::cmd_t  cmd;
  isub_pkg::stat_t stat;

  isub_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .last_i      (last_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  isub_datapath #(
    .MAX_SUBS        (MAX_SUBS),
    .MAX_CONSTRAINTS (MAX_CONSTRAINTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sub_id_i      (sub_id_i),
    .attribute_i   (attribute_i),
    .low_bound_i   (low_bound_i),
    .high_bound_i  (high_bound_i),
    .event_value_i (event_value_i),
    .last_i        (last_i),
    .stat_o        (stat),
    .match_count_o (match_count_o)
  );

endmodule

// ===== hw/rtl/isub_ctrl.sv =====
// ----------------------------------------------------------------------------
// isub_ctrl: sequencing controller
// Steps the reset clearing pass, the constraint scan of each publish word,
// the mark sweep of the last word and the output register handoff.
// ----------------------------------------------------------------------------
module isub_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           command_i,
  input  logic           last_i,
  input  logic           out_stall_i,
  input  isub_pkg::stat_t stat_i,
  output isub_pkg::cmd_t  cmd_o,
  output logic           in_stall_o,
  output logic           out_valid_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SWEEP,
    ST_SDRAIN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (command_i == isub_pkg::CMD_INSERT) begin
            cmd_o.ins_en = 1'b1;
          end else begin
            cmd_o.pub_load = 1'b1;
            if (!stat_i.store_empty) begin
              state_d = ST_SCAN;
            end else if (last_i) begin
              state_d = ST_SWEEP;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = stat_i.pub_last ? ST_SWEEP : ST_IDLE;
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) state_d = ST_SDRAIN;
      end
      ST_SDRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/isub_datapath.sv =====
// ----------------------------------------------------------------------------
// isub_datapath: constraint store, failure marks and counters
// Holds the constraint memory, the mark memory, the scan and sweep indices,
// the match accumulator and the output data register.
// ----------------------------------------------------------------------------
module isub_datapath #(
  parameter int MAX_SUBS        = isub_pkg::MAX_SUBS_DEF,
  parameter int MAX_CONSTRAINTS = isub_pkg::MAX_CONSTRAINTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  isub_pkg::cmd_t               cmd_i,
  input  logic [isub_pkg::SUB_ID_W-1:0] sub_id_i,
  input  logic [isub_pkg::ATTR_W-1:0]   attribute_i,
  input  logic [isub_pkg::VALUE_W-1:0]  low_bound_i,
  input  logic [isub_pkg::VALUE_W-1:0]  high_bound_i,
  input  logic [isub_pkg::VALUE_W-1:0]  event_value_i,
  input  logic                         last_i,
  output isub_pkg::stat_t              stat_o,
  output logic [isub_pkg::COUNT_W-1:0]  match_count_o
);

  localparam int AW = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
  localparam int CW = $clog2(MAX_CONSTRAINTS + 1);
  localparam int MW = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
  localparam int SW = $clog2(MAX_SUBS + 1);

  isub_pkg::entry_t store_mem [MAX_CONSTRAINTS];
  logic             mark_mem  [MAX_SUBS];

  logic [CW-1:0] cons_cnt_q;
  logic [SW-1:0] sub_cnt_q;
  logic [AW-1:0] scan_idx_q;
  logic [MW-1:0] mark_idx_q;
  logic [SW-1:0] match_q;
  logic          rd_vld_q;
  logic          mk_vld_q;
  logic          mk_in_q;
  logic          mk_rd_q;

  isub_pkg::entry_t             ent_q;
  isub_pkg::entry_t             ins_ent;
  logic [isub_pkg::ATTR_W-1:0]  pub_attr_q;
  logic [isub_pkg::VALUE_W-1:0] pub_val_q;
  logic                         pub_last_q;
  logic [isub_pkg::COUNT_W-1:0] out_q;

  logic          ins_ok;
  logic          fail;
  logic          mark_we;
  logic          mark_wdata;
  logic [MW-1:0] mark_waddr;
  logic [31:0]   match_ext;

  assign ins_ok = cmd_i.ins_en
               && (32'(cons_cnt_q) < MAX_CONSTRAINTS)
               && (32'(attribute_i) < isub_pkg::NUM_ATTRS);

  assign ins_ent = '{sub_id: sub_id_i, attr: attribute_i,
                     low: low_bound_i, high: high_bound_i};

  assign fail = rd_vld_q
             && (32'(pub_attr_q) < isub_pkg::NUM_ATTRS)
             && (ent_q.attr == pub_attr_q)
             && ((ent_q.low > pub_val_q) || (ent_q.high < pub_val_q))
             && (32'(ent_q.sub_id) < MAX_SUBS);

  assign mark_we    = fail || cmd_i.sweep_step || cmd_i.clr_step;
  assign mark_wdata = fail;
  assign mark_waddr = fail ? MW'(32'(ent_q.sub_id)) : mark_idx_q;

  assign stat_o.store_empty = (cons_cnt_q == '0);
  assign stat_o.scan_last   = ((32'(scan_idx_q) + 32'd1) == 32'(cons_cnt_q));
  assign stat_o.sweep_last  = (32'(mark_idx_q) == (MAX_SUBS - 1));
  assign stat_o.pub_last    = pub_last_q;

  assign match_ext     = 32'(match_q);
  assign match_count_o = out_q;

  always_ff @(posedge clk_i) begin
    if (ins_ok) store_mem[cons_cnt_q[AW-1:0]] <= ins_ent;
    if (cmd_i.scan_step) ent_q <= store_mem[scan_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
    if (cmd_i.sweep_step) mk_rd_q <= mark_mem[mark_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pub_load) begin
      pub_attr_q <= attribute_i;
      pub_val_q  <= event_value_i;
    end
    if (cmd_i.out_load) out_q <= match_ext[isub_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cons_cnt_q <= '0;
      sub_cnt_q  <= '0;
      scan_idx_q <= '0;
      mark_idx_q <= '0;
      match_q    <= '0;
      rd_vld_q   <= 1'b0;
      mk_vld_q   <= 1'b0;
      mk_in_q    <= 1'b0;
      pub_last_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      mk_vld_q <= cmd_i.sweep_step;
      mk_in_q  <= (32'(mark_idx_q) < 32'(sub_cnt_q));
      if (ins_ok) begin
        cons_cnt_q <= cons_cnt_q + CW'(1);
        if (last_i && (32'(sub_cnt_q) < MAX_SUBS)) sub_cnt_q <= sub_cnt_q + SW'(1);
      end
      if (cmd_i.pub_load) begin
        pub_last_q <= last_i;
        scan_idx_q <= '0;
        mark_idx_q <= '0;
        match_q    <= '0;
      end else begin
        if (cmd_i.scan_step) scan_idx_q <= scan_idx_q + AW'(1);
        if (cmd_i.sweep_step || cmd_i.clr_step) mark_idx_q <= mark_idx_q + MW'(1);
        if (mk_vld_q && mk_in_q && !mk_rd_q) match_q <= match_q + SW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/isub_checker.sv =====
// ----------------------------------------------------------------------------
// isub_checker: port-level checks of the interval subscription matcher
// Watches the handshakes and the result range at the top level's ports.
// ----------------------------------------------------------------------------
module isub_checker #(
  parameter int MAX_SUBS = isub_pkg::MAX_SUBS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         command_i,
  input logic [isub_pkg::SUB_ID_W-1:0] sub_id_i,
  input logic [isub_pkg::ATTR_W-1:0]   attribute_i,
  input logic [isub_pkg::VALUE_W-1:0]  low_bound_i,
  input logic [isub_pkg::VALUE_W-1:0]  high_bound_i,
  input logic [isub_pkg::VALUE_W-1:0]  event_value_i,
  input logic                         last_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [isub_pkg::COUNT_W-1:0]  match_count_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(command_i) && $stable(sub_id_i)
      && $stable(attribute_i) && $stable(low_bound_i) && $stable(high_bound_i)
      && $stable(event_value_i) && $stable(last_i))
    else $error("input word changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(match_count_o))
    else $error("result word changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(match_count_o) <= MAX_SUBS))
    else $error("match count above subscription capacity");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i == isub_pkg::CMD_PUBLISH) && last_i |=> in_stall_o)
    else $error("last event word did not start a sweep");

  a_insert_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i == isub_pkg::CMD_INSERT) |=> !in_stall_o)
    else $error("insert word took more than one cycle");

endmodule

bind interval_subscription_matcher isub_checker #(.MAX_SUBS(MAX_SUBS)) u_isub_checker (.*);
